FILE: src/nested_comment_tokenizer_defines.svh
// Assertion macros shared by the tokenizer's checker.
`ifndef NESTED_COMMENT_TOKENIZER_DEFINES_SVH
`define NESTED_COMMENT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define NCT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nct: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define NCT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nct: next-cycle check failed");

// Next-cycle implication that stays live through reset.
`define NCT_ASSERT_NEXT_ANY(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("nct: reset check failed");

`endif

FILE: src/nct_pkg.sv
// Types and codes shared by the nested comment tokenizer modules.
package nct_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       source_error;
    } in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] token_type;
        logic [7:0] text_byte;
        logic [2:0] event_code;
        logic       last;
    } out_t;

    localparam int RES_MAX = 4;

    // All results caused by one input word, in order; cnt runs from 1 to RES_MAX.
    typedef struct packed {
        out_t [RES_MAX-1:0] res;
        logic [2:0]         cnt;
    } bundle_t;

    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;

    localparam logic [3:0] TT_EOF    = 4'd0;
    localparam logic [3:0] TT_PREFIX = 4'd1;
    localparam logic [3:0] TT_LPAREN = 4'd2;
    localparam logic [3:0] TT_LBRACK = 4'd3;
    localparam logic [3:0] TT_LBRACE = 4'd4;
    localparam logic [3:0] TT_RPAREN = 4'd5;
    localparam logic [3:0] TT_RBRACK = 4'd6;
    localparam logic [3:0] TT_RBRACE = 4'd7;
    localparam logic [3:0] TT_SHORT  = 4'd8;
    localparam logic [3:0] TT_LONG   = 4'd9;
    localparam logic [3:0] TT_ERROR  = 4'd10;

    localparam logic [2:0] EV_NONE          = 3'd0;
    localparam logic [2:0] EV_BAD_CHAR      = 3'd1;
    localparam logic [2:0] EV_UNCLOSED_CMT  = 3'd2;
    localparam logic [2:0] EV_UNCLOSED_LONG = 3'd3;
    localparam logic [2:0] EV_SOURCE_ERR    = 3'd4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_HIGH = 1'b1;

    localparam int MAX_NEST_DEPTH = 255;
    localparam logic [7:0] NEST_LIMIT = 8'((MAX_NEST_DEPTH < 255) ? MAX_NEST_DEPTH : 255);

endpackage

FILE: src/nested_comment_tokenizer.sv
// Top level of the nested comment tokenizer: front end, bundle queue and output stage.
//
//   Port group   Direction  Handshake        Word
//   s_           in         s_valid/s_ready  one source byte and its read-failure flag
//   m_           out        m_valid/m_ready  one token text byte, token end or diagnostic
//   cfg_         in         cfg_we           prefix mask write, no read-back
//
// The front end takes one source word every cycle while the queue has room; all of its
// results are formed in that cycle. The output stage sends one result word per cycle
// while m_ready allows; QUEUE_DEPTH bundles absorb the bursts of words with many results.
// Results go through the queue, the bundle register and the output register in turn.
// Reset is synchronous and clears the lexer state, the prefix masks and the queue.
module nested_comment_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  nct_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output nct_pkg::out_t                  m_data,
    input  logic                           cfg_we,
    input  logic [nct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nct_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import nct_pkg::*;

    logic    push_valid, push_ready;
    bundle_t push_data;
    logic    pop_valid, pop_ready;
    bundle_t pop_data;

    nct_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    nct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    nct_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: src/nct_front.sv
// Front end: accepts source words, runs the lexer state machine and builds result bundles.
module nct_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  nct_pkg::in_t                      s_data,
    input  logic                              cfg_we,
    input  logic [nct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nct_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output logic                              push_valid,
    input  logic                              push_ready,
    output nct_pkg::bundle_t                  push_data
);
    import nct_pkg::*;

    typedef enum logic [3:0] {
        ST_BEGIN      = 4'd0,
        ST_PB_P       = 4'd1,
        ST_PB_B       = 4'd2,
        ST_PB_C       = 4'd3,
        ST_CMT_OPEN   = 4'd4,
        ST_LINE_CMT   = 4'd5,
        ST_BLOCK_CMT  = 4'd6,
        ST_BLOCK_SEMI = 4'd7,
        ST_SHORT      = 4'd8,
        ST_LONG       = 4'd9,
        ST_LONG_BAR   = 4'd10
    } state_t;

    typedef struct packed {
        state_t     st;
        logic [7:0] depth;
        logic       ended;
        logic       failed;
        logic       again;
        logic [1:0] cnt;
        out_t [1:0] res;
    } step_t;

    localparam logic [7:0] CH_EOF    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_BAR    = 8'h7c;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_DEL    = 8'h7f;

    state_t     state_reg, state_next;
    logic [7:0] depth_reg, depth_next;
    logic       ended_reg, ended_next;
    logic       failed_reg, failed_next;
    logic [CFG_DATA_W-1:0] mask_low_reg, mask_high_reg;

    step_t      step1, step2;
    bundle_t    bundle;
    logic [2:0] n_res;
    logic       live;
    logic       bad_ctrl;

    function automatic out_t mk(input logic [1:0] k, input logic [3:0] t,
                                input logic [7:0] x, input logic [2:0] e);
        out_t o;
        o.kind       = k;
        o.token_type = t;
        o.text_byte  = x;
        o.event_code = e;
        o.last       = 1'b0;
        return o;
    endfunction

    function automatic logic [3:0] bracket_type(input logic [7:0] b);
        logic [3:0] t;
        case (b)
            CH_LPAREN: t = TT_LPAREN;
            CH_LBRACK: t = TT_LBRACK;
            CH_LBRACE: t = TT_LBRACE;
            CH_RPAREN: t = TT_RPAREN;
            CH_RBRACK: t = TT_RBRACK;
            CH_RBRACE: t = TT_RBRACE;
            default:   t = TT_EOF;
        endcase
        return t;
    endfunction

    function automatic logic ends_short(input logic [7:0] b);
        logic in_set;
        logic is_elem;
        in_set  = (b == CH_BANG) || (b == CH_AT) || (b == CH_HASH) || (b == CH_LPAREN)
               || (b == CH_LBRACK) || (b == CH_LBRACE) || (b == CH_RBRACE)
               || (b == CH_RBRACK) || (b == CH_RPAREN) || (b == CH_SEMI)
               || (b == CH_COMMA);
        is_elem = b[7] || ((b > CH_SPACE) && (b < CH_DEL));
        return in_set || !is_elem;
    endfunction

    // One pass of the lexer over a byte; at most two results.
    function automatic step_t lex_step(input state_t st, input logic [7:0] depth,
                                       input logic [7:0] b, input logic [127:0] mask);
        step_t      r;
        logic [3:0] off;
        logic       is_pfx;
        logic       ignored;
        r        = '0;
        r.st     = st;
        r.depth  = depth;
        off      = (st == ST_PB_P) ? 4'd0 : ((st == ST_PB_B) ? 4'd1 : 4'd2);
        is_pfx   = (b != CH_EOF) && !b[7] && mask[b[6:0]];
        ignored  = !b[7] && ((b <= CH_SPACE) || (b == CH_DEL) || (b == CH_COMMA));
        case (st)
            ST_PB_P, ST_PB_B, ST_PB_C: begin
                r.st = ST_BEGIN;
                if (b == CH_LPAREN) begin
                    r.res[0] = mk(KIND_END, TT_LPAREN + off, 8'h00, EV_NONE);
                    r.cnt    = 2'd1;
                end else if (b == CH_RPAREN) begin
                    r.res[0] = mk(KIND_END, TT_RPAREN + off, 8'h00, EV_NONE);
                    r.cnt    = 2'd1;
                end else begin
                    r.res[0] = mk(KIND_EVENT, TT_EOF, 8'h00, EV_BAD_CHAR);
                    r.cnt    = 2'd1;
                    if (b == CH_EOF) begin
                        r.res[1] = mk(KIND_END, TT_EOF, 8'h00, EV_NONE);
                        r.cnt    = 2'd2;
                        r.ended  = 1'b1;
                    end
                end
            end
            ST_CMT_OPEN, ST_LINE_CMT: begin
                if (b == CH_NL) begin
                    r.st = ST_BEGIN;
                end else if (b == CH_EOF) begin
                    r.res[0] = mk(KIND_END, TT_EOF, 8'h00, EV_NONE);
                    r.cnt    = 2'd1;
                    r.ended  = 1'b1;
                end else if ((st == ST_CMT_OPEN) && (b == CH_SEMI)) begin
                    r.st    = ST_BLOCK_CMT;
                    r.depth = 8'd0;
                end else begin
                    r.st = ST_LINE_CMT;
                end
            end
            ST_BLOCK_CMT, ST_BLOCK_SEMI: begin
                if (b == CH_EOF) begin
                    r.res[0] = mk(KIND_EVENT, TT_EOF, 8'h00, EV_UNCLOSED_CMT);
                    r.res[1] = mk(KIND_END, TT_EOF, 8'h00, EV_NONE);
                    r.cnt    = 2'd2;
                    r.ended  = 1'b1;
                end else if (st == ST_BLOCK_CMT) begin
                    if (b == CH_SEMI) begin
                        r.st = ST_BLOCK_SEMI;
                    end
                end else begin
                    r.st = ST_BLOCK_CMT;
                    if (b == CH_SEMI) begin
                        if (depth < NEST_LIMIT) begin
                            r.depth = depth + 8'd1;
                        end
                    end else if (b == CH_EQ) begin
                        if (depth == 8'd0) begin
                            r.st = ST_BEGIN;
                        end else begin
                            r.depth = depth - 8'd1;
                        end
                    end
                end
            end
            ST_SHORT: begin
                r.cnt = 2'd1;
                if (!ends_short(b)) begin
                    r.res[0] = mk(KIND_TEXT, TT_SHORT, b, EV_NONE);
                end else begin
                    r.res[0] = mk(KIND_END, TT_SHORT, 8'h00, EV_NONE);
                    r.st     = ST_BEGIN;
                    r.again  = 1'b1;
                end
            end
            ST_LONG: begin
                if (b == CH_BAR) begin
                    r.st = ST_LONG_BAR;
                end else if (b == CH_EOF) begin
                    r.res[0] = mk(KIND_EVENT, TT_EOF, 8'h00, EV_UNCLOSED_LONG);
                    r.res[1] = mk(KIND_END, TT_ERROR, 8'h00, EV_NONE);
                    r.cnt    = 2'd2;
                    r.failed = 1'b1;
                end else begin
                    r.res[0] = mk(KIND_TEXT, TT_LONG, b, EV_NONE);
                    r.cnt    = 2'd1;
                end
            end
            ST_LONG_BAR: begin
                r.cnt = 2'd1;
                if (b == CH_BAR) begin
                    // A doubled bar stands for one bar inside the element.
                    r.res[0] = mk(KIND_TEXT, TT_LONG, CH_BAR, EV_NONE);
                    r.st     = ST_LONG;
                end else begin
                    r.res[0] = mk(KIND_END, TT_LONG, 8'h00, EV_NONE);
                    r.st     = ST_BEGIN;
                    r.again  = 1'b1;
                end
            end
            default: begin
                r.st = ST_BEGIN;
                if (b == CH_EOF) begin
                    r.res[0] = mk(KIND_END, TT_EOF, 8'h00, EV_NONE);
                    r.cnt    = 2'd1;
                    r.ended  = 1'b1;
                end else if (is_pfx) begin
                    r.res[0] = mk(KIND_TEXT, TT_PREFIX, b, EV_NONE);
                    r.res[1] = mk(KIND_END, TT_PREFIX, 8'h00, EV_NONE);
                    r.cnt    = 2'd2;
                end else if (b == CH_BANG) begin
                    r.st = ST_PB_P;
                end else if (b == CH_AT) begin
                    r.st = ST_PB_B;
                end else if (b == CH_HASH) begin
                    r.st = ST_PB_C;
                end else if (bracket_type(b) != TT_EOF) begin
                    r.res[0] = mk(KIND_END, bracket_type(b), 8'h00, EV_NONE);
                    r.cnt    = 2'd1;
                end else if (b == CH_SEMI) begin
                    r.st = ST_CMT_OPEN;
                end else if (ignored) begin
                    r.st = ST_BEGIN;
                end else if (b == CH_BAR) begin
                    r.st = ST_LONG;
                end else begin
                    r.st     = ST_SHORT;
                    r.res[0] = mk(KIND_TEXT, TT_SHORT, b, EV_NONE);
                    r.cnt    = 2'd1;
                end
            end
        endcase
        return r;
    endfunction

    assign s_ready  = push_ready;
    assign live     = s_valid && s_ready && !ended_reg && !failed_reg;
    assign bad_ctrl = (s_data.in_byte != CH_EOF)
                   && ((s_data.in_byte < CH_SPACE) || (s_data.in_byte == CH_DEL))
                   && !((s_data.in_byte >= 8'h09) && (s_data.in_byte <= 8'h0d));

    always_comb begin
        step1 = lex_step(state_reg, depth_reg, s_data.in_byte, {mask_high_reg, mask_low_reg});
        // The second pass only counts when the first one ended an element.
        step2 = lex_step(step1.st, step1.depth, s_data.in_byte, {mask_high_reg, mask_low_reg});
        bundle      = '0;
        n_res       = 3'd0;
        state_next  = state_reg;
        depth_next  = depth_reg;
        ended_next  = ended_reg;
        failed_next = failed_reg;
        if (s_data.source_error) begin
            bundle.res[0] = mk(KIND_EVENT, TT_EOF, 8'h00, EV_SOURCE_ERR);
            bundle.res[1] = mk(KIND_END, TT_ERROR, 8'h00, EV_NONE);
            n_res         = 3'd2;
            failed_next   = 1'b1;
        end else begin
            if (bad_ctrl) begin
                bundle.res[0] = mk(KIND_EVENT, TT_EOF, 8'h00, EV_BAD_CHAR);
                n_res         = 3'd1;
            end
            if (step1.cnt > 2'd0) begin
                bundle.res[n_res[1:0]] = step1.res[0];
                n_res = n_res + 3'd1;
            end
            if (step1.cnt > 2'd1) begin
                bundle.res[n_res[1:0]] = step1.res[1];
                n_res = n_res + 3'd1;
            end
            if (step1.again) begin
                if (step2.cnt > 2'd0) begin
                    bundle.res[n_res[1:0]] = step2.res[0];
                    n_res = n_res + 3'd1;
                end
                if (step2.cnt > 2'd1) begin
                    bundle.res[n_res[1:0]] = step2.res[1];
                    n_res = n_res + 3'd1;
                end
                state_next  = step2.st;
                depth_next  = step2.depth;
                ended_next  = step2.ended;
                failed_next = step2.failed;
            end else begin
                state_next  = step1.st;
                depth_next  = step1.depth;
                ended_next  = step1.ended;
                failed_next = step1.failed;
            end
        end
        if (n_res != 3'd0) begin
            bundle.res[2'(n_res - 3'd1)].last = 1'b1;
        end
        bundle.cnt = n_res;
    end

    assign push_valid = live && (n_res != 3'd0);
    assign push_data  = bundle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_BEGIN;
            depth_reg     <= 8'd0;
            ended_reg     <= 1'b0;
            failed_reg    <= 1'b0;
            mask_low_reg  <= '0;
            mask_high_reg <= '0;
        end else begin
            if (live) begin
                state_reg  <= state_next;
                depth_reg  <= depth_next;
                ended_reg  <= ended_next;
                failed_reg <= failed_next;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_PREFIX_LOW:  mask_low_reg  <= cfg_wdata;
                    REG_PREFIX_HIGH: mask_high_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: src/nct_queue.sv
// Short queue of result bundles between the lexer front end and the output stage.
module nct_queue #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  nct_pkg::bundle_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output nct_pkg::bundle_t pop_data
);
    import nct_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bundle_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/nct_back.sv
// Output stage: unpacks each bundle into single result words behind an output register.
module nct_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  nct_pkg::bundle_t pop_data,
    output logic             m_valid,
    input  logic             m_ready,
    output nct_pkg::out_t    m_data
);
    import nct_pkg::*;

    bundle_t    cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    out_t       m_data_reg, m_data_next;
    logic       out_load, cur_done;

    always_comb begin
        out_load  = cur_valid_reg && (!m_valid_reg || m_ready);
        cur_done  = out_load && ({1'b0, idx_reg} == (cur_reg.cnt - 3'd1));
        // A new bundle moves in as soon as the last word of the current one leaves.
        pop_ready = !cur_valid_reg || cur_done;

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop_valid && pop_ready) begin
            cur_next       = pop_data;
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end else if (cur_done) begin
            cur_valid_next = 1'b0;
        end else if (out_load) begin
            idx_next = idx_reg + 2'd1;
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = cur_reg.res[idx_reg];
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: src/nct_checker.sv
// Port-level checks for the nested comment tokenizer, bound to its top level.
`include "nested_comment_tokenizer_defines.svh"

module nct_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input nct_pkg::out_t m_data
);
    import nct_pkg::*;

    logic in_take;

    assign in_take = s_valid && s_ready;

    // A word that has not been taken stays on the port unchanged.
    `NCT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // Diagnostics carry an event code and nothing else.
    `NCT_ASSERT_IMPL(a_event_clean, aclk, aresetn, m_valid && (m_data.kind == KIND_EVENT), (m_data.event_code != EV_NONE) && (m_data.token_type == TT_EOF) && (m_data.text_byte == 8'h00))

    // Token ends carry neither text nor an event code, and no other kind appears.
    `NCT_ASSERT_IMPL(a_kind_fields, aclk, aresetn, m_valid && (m_data.kind != KIND_EVENT), ((m_data.kind == KIND_TEXT) || (m_data.kind == KIND_END)) && (m_data.event_code == EV_NONE) && ((m_data.kind == KIND_TEXT) || (m_data.text_byte == 8'h00)))

    // Reset empties the output side.
    `NCT_ASSERT_NEXT_ANY(a_reset_clear, aclk, !aresetn, !m_valid && !$past(in_take))

endmodule

bind nested_comment_tokenizer nct_checker u_nct_checker (.*);

FILE: tb/sv/tb_nested_comment_tokenizer.sv
// Self-checking testbench for the nested comment tokenizer: random bytes, masks and stalls.
module tb_nested_comment_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import nct_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 400;

    typedef enum logic [3:0] {
        LX_BEGIN, LX_MARK_P, LX_MARK_B, LX_MARK_C, LX_SEMI, LX_LINE,
        LX_BLOCK, LX_BLOCK_SEMI, LX_SHORT, LX_LONG, LX_LONG_BAR
    } lex_state_e;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Lexer state as the testbench expects it, plus its copy of the prefix masks.
    lex_state_e  lx_state  = LX_BEGIN;
    logic [7:0]  lx_depth  = 8'd0;
    logic        lx_ended  = 1'b0;
    logic        lx_failed = 1'b0;
    logic [63:0] pmask_lo  = '0;
    logic [63:0] pmask_hi  = '0;

    in_t   source_words[$];
    out_t  step_results[$];
    out_t  pending_tokens[$];

    int    words_in = 0;
    int    words_out = 0;
    int    mismatches = 0;
    int    prefix_settings = 0;
    int    cycle_count = 0;
    int    hold_left = 0;
    int    tx_wait = 0;
    int    tx_run = 0;
    int    rx_wait = 0;
    int    rx_run = 0;
    string end_case = "none";

    nested_comment_tokenizer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void add_result(logic [1:0] k, logic [3:0] tt, logic [7:0] tb,
                                       logic [2:0] ev);
        out_t r;
        if (step_results.size() < RES_MAX) begin
            r = '{kind: k, token_type: tt, text_byte: tb, event_code: ev, last: 1'b0};
            step_results.push_back(r);
        end
    endfunction

    function automatic logic prefix_byte(logic [7:0] b);
        if (b == 8'd0 || b[7])
            return 1'b0;
        return b[6] ? pmask_hi[b[5:0]] : pmask_lo[b[5:0]];
    endfunction

    function automatic logic control_byte(logic [7:0] b);
        return b < 8'd32 || b == 8'd127;
    endfunction

    function automatic logic space_byte(logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic element_char(logic [7:0] b);
        return b[7] || (b > 8'd32 && b < 8'd127);
    endfunction

    function automatic logic ends_short(logic [7:0] b);
        case (b)
            "!", "@", "#", "(", "[", "{", "}", "]", ")", ";", ",": return 1'b1;
            default: return !element_char(b);
        endcase
    endfunction

    // A plain bracket gives its token type; anything else gives zero.
    function automatic logic [3:0] bracket_kind(logic [7:0] b);
        case (b)
            "(": return TT_LPAREN;
            "[": return TT_LBRACK;
            "{": return TT_LBRACE;
            ")": return TT_RPAREN;
            "]": return TT_RBRACK;
            "}": return TT_RBRACE;
            default: return TT_EOF;
        endcase
    endfunction

    function automatic void finish_input();
        add_result(KIND_END, TT_EOF, 8'd0, EV_NONE);
        lx_ended = 1'b1;
    endfunction

    // Returns 1 when the byte closed an element and must be looked at again.
    function automatic bit lex_byte(logic [7:0] b);
        logic [1:0] off;
        case (lx_state)
            LX_MARK_P, LX_MARK_B, LX_MARK_C: begin
                off = 2'(lx_state - LX_MARK_P);
                lx_state = LX_BEGIN;
                if (b == "(") begin
                    add_result(KIND_END, TT_LPAREN + off, 8'd0, EV_NONE);
                end else if (b == ")") begin
                    add_result(KIND_END, TT_RPAREN + off, 8'd0, EV_NONE);
                end else begin
                    add_result(KIND_EVENT, TT_EOF, 8'd0, EV_BAD_CHAR);
                    if (b == 8'd0)
                        finish_input();
                end
                return 1'b0;
            end
            LX_SEMI, LX_LINE: begin
                if (b == "\n")
                    lx_state = LX_BEGIN;
                else if (b == 8'd0)
                    finish_input();
                else if (lx_state == LX_SEMI && b == ";") begin
                    lx_state = LX_BLOCK;
                    lx_depth = 8'd0;
                end else
                    lx_state = LX_LINE;
                return 1'b0;
            end
            LX_BLOCK, LX_BLOCK_SEMI: begin
                if (b == 8'd0) begin
                    add_result(KIND_EVENT, TT_EOF, 8'd0, EV_UNCLOSED_CMT);
                    finish_input();
                end else if (lx_state == LX_BLOCK) begin
                    if (b == ";")
                        lx_state = LX_BLOCK_SEMI;
                end else begin
                    lx_state = LX_BLOCK;
                    if (b == ";") begin
                        if (lx_depth < NEST_LIMIT)
                            lx_depth++;
                    end else if (b == "=") begin
                        if (lx_depth == 8'd0)
                            lx_state = LX_BEGIN;
                        else
                            lx_depth--;
                    end
                end
                return 1'b0;
            end
            LX_SHORT: begin
                if (!ends_short(b)) begin
                    add_result(KIND_TEXT, TT_SHORT, b, EV_NONE);
                    return 1'b0;
                end
                add_result(KIND_END, TT_SHORT, 8'd0, EV_NONE);
                lx_state = LX_BEGIN;
                return 1'b1;
            end
            LX_LONG: begin
                if (b == "|") begin
                    lx_state = LX_LONG_BAR;
                end else if (b == 8'd0) begin
                    add_result(KIND_EVENT, TT_EOF, 8'd0, EV_UNCLOSED_LONG);
                    add_result(KIND_END, TT_ERROR, 8'd0, EV_NONE);
                    lx_failed = 1'b1;
                end else
                    add_result(KIND_TEXT, TT_LONG, b, EV_NONE);
                return 1'b0;
            end
            LX_LONG_BAR: begin
                if (b == "|") begin
                    add_result(KIND_TEXT, TT_LONG, "|", EV_NONE);
                    lx_state = LX_LONG;
                    return 1'b0;
                end
                add_result(KIND_END, TT_LONG, 8'd0, EV_NONE);
                lx_state = LX_BEGIN;
                return 1'b1;
            end
            default: begin
                lx_state = LX_BEGIN;
                if (b == 8'd0) begin
                    finish_input();
                end else if (prefix_byte(b)) begin
                    add_result(KIND_TEXT, TT_PREFIX, b, EV_NONE);
                    add_result(KIND_END, TT_PREFIX, 8'd0, EV_NONE);
                end else if (b == "!") begin
                    lx_state = LX_MARK_P;
                end else if (b == "@") begin
                    lx_state = LX_MARK_B;
                end else if (b == "#") begin
                    lx_state = LX_MARK_C;
                end else if (bracket_kind(b) != TT_EOF) begin
                    add_result(KIND_END, bracket_kind(b), 8'd0, EV_NONE);
                end else if (b == ";") begin
                    lx_state = LX_SEMI;
                end else if (!(!b[7] && (control_byte(b) || space_byte(b) || b == ","))) begin
                    if (b == "|") begin
                        lx_state = LX_LONG;
                    end else begin
                        lx_state = LX_SHORT;
                        add_result(KIND_TEXT, TT_SHORT, b, EV_NONE);
                    end
                end
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void lex_word(in_t w);
        out_t r;
        step_results.delete();
        if (lx_ended || lx_failed)
            return;
        if (w.source_error) begin
            add_result(KIND_EVENT, TT_EOF, 8'd0, EV_SOURCE_ERR);
            add_result(KIND_END, TT_ERROR, 8'd0, EV_NONE);
            lx_failed = 1'b1;
        end else begin
            // A control byte is reported once, even when an element end makes it go round twice.
            if (w.in_byte != 8'd0 && control_byte(w.in_byte) && !space_byte(w.in_byte))
                add_result(KIND_EVENT, TT_EOF, 8'd0, EV_BAD_CHAR);
            if (lex_byte(w.in_byte))
                void'(lex_byte(w.in_byte));
        end
        foreach (step_results[i]) begin
            r = step_results[i];
            r.last = (i == step_results.size() - 1);
            pending_tokens.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic int draw_gap(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            run = $urandom_range(10, 40);
        return $urandom_range(0, 15);
    endfunction

    function automatic void push_byte(logic [7:0] b);
        source_words.push_back('{in_byte: b, source_error: 1'b0});
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic logic [7:0] element_byte();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(128, 255));
            1: return 8'($urandom_range(33, 126));
            default: return 8'($urandom_range(8'h61, 8'h7a));
        endcase
    endfunction

    // Comment filler: anything but the semicolon and the end-of-input byte.
    function automatic void push_filler();
        logic [7:0] b;
        repeat ($urandom_range(0, 3)) begin
            do b = 8'($urandom_range(1, 255)); while (b == ";");
            push_byte(b);
        end
    endfunction

    function automatic void add_fragment();
        string      marks = "!@#";
        string      brackets = "([{)]}";
        string      prefixes = "$&^~%'";
        string      separators = " ,\t\n\r";
        int         depth;
        logic [7:0] b;
        case ($urandom_range(0, 15))
            0, 1: begin
                if ($urandom_range(0, 1))
                    push_byte(marks[$urandom_range(0, 2)]);
                push_byte(brackets[$urandom_range(0, 5)]);
            end
            2: begin
                // Mark followed by any nonzero byte, which may also be a bracket.
                push_byte(marks[$urandom_range(0, 2)]);
                push_byte(8'($urandom_range(1, 255)));
            end
            3, 4, 5: repeat ($urandom_range(1, 6)) push_byte(element_byte());
            6, 7: begin
                push_text("|");
                repeat ($urandom_range(0, 6)) begin
                    b = 8'($urandom_range(1, 255));
                    push_byte(b);
                    if (b == "|")
                        push_byte(b);
                end
                push_text("|");
            end
            8: begin
                push_text(";");
                repeat ($urandom_range(0, 5)) begin
                    do b = 8'($urandom_range(1, 255)); while (b == "\n" || b == ";");
                    push_byte(b);
                end
                push_text("\n");
            end
            9: begin
                depth = $urandom_range(0, 3);
                push_text(";;");
                push_filler();
                repeat (depth) begin
                    push_text(";;");
                    push_filler();
                end
                repeat (depth + 1) begin
                    push_text(";=");
                    push_filler();
                end
            end
            10: push_byte(prefixes[$urandom_range(0, 5)]);
            11: push_byte(8'($urandom_range(1, 31)));
            12: push_byte(8'($urandom_range(1, 255)));
            default: push_byte(separators[$urandom_range(0, 4)]);
        endcase
    endfunction

    function automatic void add_random(int n);
        int target;
        target = source_words.size() + n;
        while (source_words.size() < target)
            add_fragment();
    endfunction

    // The block stays ended or failed for good, so one run ends in exactly one way,
    // and every word after that must be swallowed.
    function automatic void add_ending();
        case ($urandom_range(0, 6))
            0: begin
                end_case = "end of input between tokens";
                push_text(" ");
                push_byte(8'd0);
            end
            1: begin
                end_case = "end of input inside a line comment";
                if ($urandom_range(0, 1))
                    push_text(";ab");
                else
                    push_text(";");
                push_byte(8'd0);
            end
            2: begin
                end_case = "end of input inside a nested comment";
                push_text(";;a;;b");
                push_byte(8'd0);
            end
            3: begin
                end_case = "end of input inside a long element";
                push_text(" |ab");
                push_byte(8'd0);
            end
            4: begin
                end_case = "end of input after a bracket mark";
                push_text(" !");
                push_byte(8'd0);
            end
            5: begin
                end_case = "end of input straight after a short element";
                push_text(" ab");
                push_byte(8'd0);
            end
            default: begin
                end_case = "source read failure";
                push_text(" x");
                source_words.push_back('{in_byte: 8'($urandom), source_error: 1'b1});
            end
        endcase
        repeat (3) push_byte(element_byte());
        push_byte(8'd0);
        source_words.push_back('{in_byte: 8'hff, source_error: 1'b1});
        source_words.push_back('{in_byte: 8'($urandom_range(1, 255)), source_error: 1'b1});
    endfunction

    task automatic write_prefix_masks(logic [63:0] lo, logic [63:0] hi);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PREFIX_LOW;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= REG_PREFIX_HIGH;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        pmask_lo = lo;
        pmask_hi = hi;
        prefix_settings++;
    endtask

    // A word that yields nothing may still be in the pipe when the last result has left.
    task automatic wait_drained();
        do @(negedge aclk);
        while (source_words.size() != 0 || s_valid || pending_tokens.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                lex_word(s_data);
                words_in++;
            end
            if (!s_valid || s_ready) begin
                // During the receiver's long hold the sender keeps pushing without gaps.
                if (tx_wait != 0 && hold_left == 0) begin
                    tx_wait--;
                    s_valid <= 1'b0;
                end else if (source_words.size() != 0) begin
                    s_data  <= source_words.pop_front();
                    s_valid <= 1'b1;
                    tx_wait = draw_gap(tx_run);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    function automatic void compare_field(string fname, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            $display("%0t: result word %0d, %s expected %0d, got %0d",
                     $time, words_out, fname, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_side
        int   hold_nx;
        out_t want;
        hold_nx = hold_left;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_nx = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_tokens.size() == 0) begin
                    $display("%0t: result word %0d arrived with nothing expected, got %p",
                             $time, words_out, m_data);
                    mismatches++;
                end else begin
                    want = pending_tokens.pop_front();
                    compare_field("kind", 8'(m_data.kind), 8'(want.kind));
                    compare_field("token_type", 8'(m_data.token_type), 8'(want.token_type));
                    compare_field("text_byte", m_data.text_byte, want.text_byte);
                    compare_field("event_code", 8'(m_data.event_code), 8'(want.event_code));
                    compare_field("last", 8'(m_data.last), 8'(want.last));
                end
                words_out++;
                rx_wait = draw_gap(rx_run);
                if (words_out == HOLD_AT)
                    hold_nx = HOLD_CYCLES;
            end else if (hold_left != 0) begin
                hold_nx = hold_left - 1;
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_ready <= (hold_nx == 0 && rx_wait == 0);
        end
        hold_left <= hold_nx;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles, %0d result words still expected",
                     $time, cycle_count, pending_tokens.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Byte 1, '$' and '&' below 64, '^' and '~' above.
        write_prefix_masks(64'h0000_0050_0000_0002, 64'h4000_0000_4000_0000);
        push_text("([{)]}!(@[#)");
        // High-bit short element closed by a control byte that is also a prefix.
        push_byte(8'hff);
        push_byte(8'h80);
        push_byte(8'h01);
        push_text("|||");
        push_byte(8'h01);
        push_text("|");
        push_byte(8'h7f);
        push_text(";;;;;=;=");
        add_random(100);
        wait_drained();

        write_prefix_masks({$urandom, $urandom}, {$urandom, $urandom});
        add_random(80);
        wait_drained();

        write_prefix_masks('1, '1);
        add_random(50);
        wait_drained();

        // A comment twenty levels deep; it only closes once every level is matched.
        write_prefix_masks('0, '0);
        push_text(" ;;");
        repeat (20) push_text(";;");
        repeat (21) push_text(";=");
        push_text("z ");
        add_random(70);
        add_ending();
        wait_drained();

        $display("summary: %0d source words, %0d result words checked, %0d prefix mask settings",
                 words_in, words_out, prefix_settings);
        $display("summary: stream closed by %s, a deeply nested comment opened and closed",
                 end_case);
        if (pending_tokens.size() != 0)
            $display("%0t: %0d result words never arrived", $time, pending_tokens.size());
        if (mismatches == 0 && pending_tokens.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
